[rtl/aesctr_pkg.sv]
// Package for the AES-128 counter-mode stream unit.
// Holds the register map, types, S-box, round constants and helpers; no dependencies.
`default_nettype none
package aesctr_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned AddrWidth = 5;
    localparam logic [AddrWidth-1:0] RegKeyLow  = 5'h00;
    localparam logic [AddrWidth-1:0] RegKeyHigh = 5'h08;
    localparam logic [AddrWidth-1:0] RegIvLow   = 5'h10;
    localparam logic [AddrWidth-1:0] RegIvHigh  = 5'h18;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic valid;
        block_t state;
        block_t rkey;
        block_t data;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key; byte n of the block sits in bits 8n+7:8n.
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] t;
        block_t n;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        next_key = n;
    endfunction
endpackage
`default_nettype wire

[rtl/aesctr_round_cell.sv]
// One AES round cell of the pipeline: round function and key expansion step.
// Depends on aesctr_pkg.
`default_nettype none
module aesctr_round_cell #(
    parameter int unsigned ROUND = 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire aesctr_pkg::stage_t prev,
    output aesctr_pkg::stage_t stage
);
    import aesctr_pkg::*;

    logic   valid_reg;
    block_t state_reg;
    block_t rkey_reg;
    block_t data_reg;
    stage_t stage_next;
    block_t sub;
    block_t mixed;
    block_t rk;

    always_comb
    begin
        // SubBytes and ShiftRows: byte (row, col) at index 4*col+row.
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sub[8*(4*c+i) +: 8] = SBOX[prev.state[8*(4*((c+i)%4)+i) +: 8]];
            end
        end
        mixed = sub;
        if (ROUND != NumRounds) begin
            for (int c = 0; c < 4; c++) begin
                logic [7:0] a0, a1, a2, a3, al;
                a0 = sub[8*(4*c)   +: 8];
                a1 = sub[8*(4*c+1) +: 8];
                a2 = sub[8*(4*c+2) +: 8];
                a3 = sub[8*(4*c+3) +: 8];
                al = a0 ^ a1 ^ a2 ^ a3;
                mixed[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                mixed[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                mixed[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                mixed[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        rk = next_key(prev.rkey, RCON[ROUND-1]);
        stage_next.valid = prev.valid;
        stage_next.state = mixed ^ rk;
        stage_next.rkey  = rk;
        stage_next.data  = prev.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            state_reg <= stage_next.state;
            rkey_reg  <= stage_next.rkey;
            data_reg  <= stage_next.data;
        end
    end

    assign stage = {valid_reg, state_reg, rkey_reg, data_reg};
endmodule
`default_nettype wire

[rtl/aes128_counter_stream_crypt_unit.sv]
// Top level of the AES-128 counter-mode stream unit: registers, counter,
// input cell, ten round cells and output XOR. Depends on aesctr_pkg and aesctr_round_cell.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, data_low, data_high, restart
//  out     | output    | out_valid, out_ready, out_low, out_high
//  cfg     | input     | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One word per cycle unless stalled; each word passes the input cell and ten round cells.
// The whole chain moves together and halts when the last cell holds a word
// that is not taken. Reset clears valid bits, counter and registers.
`default_nettype none
module aes128_counter_stream_crypt_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_low,
    input  wire logic [63:0] data_high,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_low,
    output logic [63:0]      out_high,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [aesctr_pkg::AddrWidth-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import aesctr_pkg::*;

    logic [63:0] key_low_reg, key_high_reg, iv_low_reg, iv_high_reg;
    logic [31:0] ctr_reg;
    logic [31:0] ctr_use;
    logic        advance;
    logic        wr_en;
    stage_t      chain [NumRounds+1];
    logic        first_valid_reg;
    block_t      first_state_reg;
    block_t      first_rkey_reg;
    block_t      first_data_reg;
    block_t      ctr_blk;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign advance = !chain[NumRounds].valid || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        case (paddr)
            RegKeyLow:  prdata = key_low_reg;
            RegKeyHigh: prdata = key_high_reg;
            RegIvLow:   prdata = iv_low_reg;
            RegIvHigh:  prdata = iv_high_reg;
            default:    prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_low_reg  <= 64'h0;
            key_high_reg <= 64'h0;
            iv_low_reg   <= 64'h0;
            iv_high_reg  <= 64'h0;
        end else if (wr_en) begin
            case (paddr)
                RegKeyLow:  key_low_reg  <= pwdata;
                RegKeyHigh: key_high_reg <= pwdata;
                RegIvLow:   iv_low_reg   <= pwdata;
                RegIvHigh:  iv_high_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    assign ctr_use = restart ? iv_low_reg[31:0] : ctr_reg;
    assign ctr_blk = {iv_high_reg, iv_low_reg[63:32], ctr_use};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctr_reg         <= 32'h0;
            first_valid_reg <= 1'b0;
        end else if (advance) begin
            first_valid_reg <= in_valid;
            if (in_valid) begin
                ctr_reg <= ctr_use + 32'd1;
            end
        end
    end

    // Initial AddRoundKey happens in the input cell.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            first_state_reg <= ctr_blk ^ {key_high_reg, key_low_reg};
            first_rkey_reg  <= {key_high_reg, key_low_reg};
            first_data_reg  <= {data_high, data_low};
        end
    end

    assign chain[0] = {first_valid_reg, first_state_reg, first_rkey_reg, first_data_reg};

    for (genvar r = 1; r <= NumRounds; r++) begin : g_round
        aesctr_round_cell #(.ROUND(r)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (chain[r-1]),
            .stage   (chain[r])
        );
    end

    assign out_valid = chain[NumRounds].valid;
    assign out_low   = chain[NumRounds].data[63:0]   ^ chain[NumRounds].state[63:0];
    assign out_high  = chain[NumRounds].data[127:64] ^ chain[NumRounds].state[127:64];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_low))
        else $error("output word changed while stalled");
    a_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ctr_reg == $past(ctr_use) + 32'd1)
        else $error("counter did not advance");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(ctr_reg))
        else $error("counter moved during stall");
endmodule
`default_nettype wire

[tb/tb_aes128_counter_stream_crypt_unit.sv]
// Testbench for the AES-128 counter-mode stream unit: random and directed words
// checked against an in-bench cipher model. Depends on aesctr_pkg and the unit RTL.
`default_nettype none

class ctr_scoreboard;
    logic [63:0] key_lo, key_hi, iv_lo, iv_hi;
    logic [31:0] ctr_word;
    logic [127:0] pending_q[$];
    int errors;
    int matched;

    function new();
        key_lo = '0; key_hi = '0; iv_lo = '0; iv_hi = '0;
        ctr_word = '0; errors = 0; matched = 0;
    endfunction

    function logic [7:0] sub(input logic [7:0] v);
        return aesctr_pkg::SBOX[v];
    endfunction

    function logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a block sits in bits 8n+7:8n; column c holds bytes 4c..4c+3.
    function logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] blk);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a, b, d, e, tmp, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            a = rk[i-4]; b = rk[i-3]; d = rk[i-2]; e = rk[i-1];
            if ((i % 16) == 0)
            begin
                tmp = a;
                a = sub(b) ^ aesctr_pkg::RCON[i/16 - 1];
                b = sub(d); d = sub(e); e = sub(tmp);
            end
            rk[i] = rk[i-16] ^ a; rk[i+1] = rk[i-15] ^ b;
            rk[i+2] = rk[i-14] ^ d; rk[i+3] = rk[i-13] ^ e;
        end
        for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[4*c+i] = sub(s[4*((c+i)%4)+i]);
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
                    all = a ^ b ^ d ^ e;
                    t[4*c]   = a ^ all ^ dbl(a ^ b);
                    t[4*c+1] = b ^ all ^ dbl(b ^ d);
                    t[4*c+2] = d ^ all ^ dbl(d ^ e);
                    t[4*c+3] = e ^ all ^ dbl(e ^ a);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
        return res;
    endfunction

    function void note_block(input logic [63:0] lo, input logic [63:0] hi, input logic rs);
        logic [127:0] ks;
        logic [127:0] expect_word;
        if (rs) ctr_word = iv_lo[31:0];
        ks = encrypt({key_hi, key_lo}, {iv_hi, iv_lo[63:32], ctr_word});
        ctr_word = ctr_word + 32'd1;
        expect_word = {hi, lo} ^ ks;
        pending_q = {pending_q, expect_word};
    endfunction

    function void check_block(input logic [63:0] lo, input logic [63:0] hi);
        logic [127:0] want;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected output word %h_%h", $time, hi, lo);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (lo !== want[63:0])
        begin
            $display("%0t: out_low expected %h actual %h", $time, want[63:0], lo);
            errors++;
        end
        if (hi !== want[127:64])
        begin
            $display("%0t: out_high expected %h actual %h", $time, want[127:64], hi);
            errors++;
        end
        matched++;
    endfunction
endclass

module tb_aes128_counter_stream_crypt_unit;
    import aesctr_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [63:0] data_low = '0;
    logic [63:0] data_high = '0;
    logic restart = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [63:0] out_low, out_high;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    ctr_scoreboard sb = new();
    bit no_idle = 1'b0;
    int hold_cycles = 0;
    int restarts = 0;

    aes128_counter_stream_crypt_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_low(data_low), .data_high(data_high), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_low(out_low), .out_high(out_high),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [63:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (addr)
            RegKeyLow:  sb.key_lo = value;
            RegKeyHigh: sb.key_hi = value;
            RegIvLow:   sb.iv_lo = value;
            RegIvHigh:  sb.iv_hi = value;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (prdata !== value)
        begin
            $display("%0t: prdata expected %h actual %h", $time, value, prdata);
            sb.errors++;
        end
        @(negedge clk);
    endtask

    task automatic set_all(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] v0, input logic [63:0] v1);
        write_reg(RegKeyLow, k0);
        write_reg(RegKeyHigh, k1);
        write_reg(RegIvLow, v0);
        write_reg(RegIvHigh, v1);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance with
    // in_valid still high, so the caller must offer a new word or go idle.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic rs);
        if (!no_idle)
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1; data_low <= lo; data_high <= hi; restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_block(lo, hi, rs);
        if (rs) restarts++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (15) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_block(out_low, out_high);

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    initial
    begin
        #20000000;
        $display("aes128_counter_stream_crypt_unit test failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset key and iv, then extremes, wrap and restart cases.
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        drain();
        set_all('1, '1, 64'hffff_ffff_ffff_fffd, '1);
        send_block('0, '0, 1'b1);
        send_block('1, '1, 1'b0);
        send_block('0, '1, 1'b0);
        send_block('1, '0, 1'b0);   // the counter word has wrapped to zero here
        drain();
        // An iv write alone leaves the counter alone until a restart.
        write_reg(RegIvLow, 64'h0000_0000_1234_5678);
        send_block(rand64(), rand64(), 1'b0);
        send_block(rand64(), rand64(), 1'b1);
        send_block(rand64(), rand64(), 1'b1);
        drain();
        set_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '0, '0);
        send_block('0, '0, 1'b1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            set_all(rand64(), rand64(), {$urandom(), 32'hffff_fff0 | $urandom_range(15)},
                    rand64());
            no_idle = (phase == 3);
            for (int n = 0; n < 100; n++)
            begin
                if (phase == 2 && n == 20)
                    hold_cycles = 80;
                if (phase == 4 && n == 50)
                    drain();
                send_block(rand64(), rand64(), (n == 0) || ($urandom_range(19) == 0));
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Checked %0d words over several key and iv settings, %0d restarts,",
                 sb.matched, restarts);
        $display("including counter wrap, output back-pressure and idle-free stretches.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("aes128_counter_stream_crypt_unit test passed");
        else
            $display("aes128_counter_stream_crypt_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
